// File: hw/rtl/lr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared request kinds and the stepper status group.
// ----------------------------------------------------------------------------
package lr_pkg;

  // Request kind as carried on the input and through the command queue.
  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } lr_kind_e;

  // Status of the back part, seen by the top level and its queues.
  typedef struct packed {
    logic cmd_pop;   // a command is taken from the command queue
    logic res_push;  // a pixel is written into the result queue
    logic active;    // a line is in progress
  } lr_back_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/lr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer queue
// Small synchronous first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module lr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output      logic             full_o,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output      logic             empty_o,
  output      logic [WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer front part
// Classifies requests and prepares deltas, directions and initial error.
// ----------------------------------------------------------------------------
module lr_front import lr_pkg::*; #(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire logic                  kind_i,
  input  wire logic [COORD_BITS-1:0] x_start_i,
  input  wire logic [COORD_BITS-1:0] y_start_i,
  input  wire logic [COORD_BITS-1:0] x_end_i,
  input  wire logic [COORD_BITS-1:0] y_end_i,
  output      lr_kind_e              op_o,
  output      logic [COORD_BITS-1:0] dx_o,
  output      logic [COORD_BITS-1:0] dy_o,
  output      logic                  sx_neg_o,
  output      logic                  sy_neg_o,
  output      logic signed [COORD_BITS+1:0] err_o
);

  logic [COORD_BITS-1:0] dx, dy;

  always_comb begin
    op_o     = lr_kind_e'(kind_i);
    sx_neg_o = !(x_start_i < x_end_i);
    sy_neg_o = !(y_start_i < y_end_i);
    dx = (x_end_i >= x_start_i) ? (x_end_i - x_start_i) : (x_start_i - x_end_i);
    dy = (y_end_i >= y_start_i) ? (y_end_i - y_start_i) : (y_start_i - y_end_i);
    dx_o = dx;
    dy_o = dy;
    // Half the major delta, negative when the line is y-major or diagonal.
    if (dx > dy) begin
      err_o = $signed({2'b00, dx >> 1});
    end else begin
      err_o = -$signed({2'b00, dy >> 1});
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer back part
// Holds the line state and makes one Bresenham step per advance command.
// ----------------------------------------------------------------------------
module lr_back import lr_pkg::*; #(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_empty_i,
  input  wire lr_kind_e              op_i,
  input  wire logic [COORD_BITS-1:0] x0_i,
  input  wire logic [COORD_BITS-1:0] y0_i,
  input  wire logic [COORD_BITS-1:0] x1_i,
  input  wire logic [COORD_BITS-1:0] y1_i,
  input  wire logic [COORD_BITS-1:0] dx_i,
  input  wire logic [COORD_BITS-1:0] dy_i,
  input  wire logic                  sx_neg_i,
  input  wire logic                  sy_neg_i,
  input  wire logic signed [COORD_BITS+1:0] err_i,
  input  wire logic                  res_full_i,
  output      lr_back_stat_t         stat_o,
  output      logic [COORD_BITS-1:0] pixel_x_o,
  output      logic [COORD_BITS-1:0] pixel_y_o,
  output      logic                  last_o
);

  localparam int unsigned EW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic [COORD_BITS-1:0] dx_q, dx_d, dy_q, dy_d;
  logic                  sx_neg_q, sx_neg_d, sy_neg_q, sy_neg_d;
  logic signed [EW-1:0]  err_q, err_d;
  logic                  active_q, active_d;

  logic                  fire, step_x, step_y, done;
  logic signed [EW-1:0]  dxs, dys, err_step;
  logic [COORD_BITS-1:0] nx, ny;

  always_comb begin
    fire = !cmd_empty_i && !res_full_i;
    dxs  = $signed({2'b00, dx_q});
    dys  = $signed({2'b00, dy_q});
    step_x = (err_q > -dxs);
    step_y = (err_q < dys);
    err_step = err_q - (step_x ? dys : EW'(0)) + (step_y ? dxs : EW'(0));
    nx = step_x ? (sx_neg_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1))
                : cur_x_q;
    ny = step_y ? (sy_neg_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1))
                : cur_y_q;

    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    sx_neg_d = sx_neg_q;
    sy_neg_d = sy_neg_q;
    err_d    = err_q;
    active_d = active_q;

    if (op_i == KIND_START) begin
      pixel_x_o = x0_i;
      pixel_y_o = y0_i;
      done      = (x0_i == x1_i) && (y0_i == y1_i);
    end else begin
      pixel_x_o = nx;
      pixel_y_o = ny;
      done      = (nx == goal_x_q) && (ny == goal_y_q);
    end
    last_o = done;

    stat_o.cmd_pop  = fire;
    stat_o.res_push = fire && ((op_i == KIND_START) || active_q);
    stat_o.active   = active_q;

    if (fire) begin
      if (op_i == KIND_START) begin
        cur_x_d  = x0_i;
        cur_y_d  = y0_i;
        goal_x_d = x1_i;
        goal_y_d = y1_i;
        dx_d     = dx_i;
        dy_d     = dy_i;
        sx_neg_d = sx_neg_i;
        sy_neg_d = sy_neg_i;
        err_d    = err_i;
        active_d = !done;
      end else if (active_q) begin
        cur_x_d  = nx;
        cur_y_d  = ny;
        err_d    = err_step;
        active_d = !done;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    goal_x_q <= goal_x_d;
    goal_y_q <= goal_y_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    sx_neg_q <= sx_neg_d;
    sy_neg_q <= sy_neg_d;
    err_q    <= err_d;
  end

endmodule
`default_nettype wire

// File: hw/rtl/line_rasterizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer top level
// Bresenham line stepper with queue-style request and pixel channels.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake     | Payload                                  | Dir
//  ----------+---------------+------------------------------------------+----
//  request   | push / full   | kind_i, x_start_i, y_start_i, x_end_i,   | in
//            |               | y_end_i                                  |
//  pixel     | empty / pop   | pixel_x_o, pixel_y_o, last_o             | out
//
//  One request is taken per cycle while full is low. A request waits in the
//  command queue until the stepper writes its pixel into the result queue,
//  from which the pixel shows on the result ports. The rate is set by the
//  stepper's error update, which completes one step per cycle unless stalled.
//  Reset empties both queues and leaves no line in progress.
//  The stepper holds off whenever the result queue is full, even for an
//  advance that makes no pixel; full rises once the command queue holds two
//  requests, and no request or pixel is lost.
//
// The front part classifies each request and, for a start request, works out
// the absolute deltas, the step directions and the initial error term. These
// travel through a short command queue to the back part, which holds the line
// state and performs one Bresenham step per advance request. An advance
// request while no line is in progress is consumed silently.
module line_rasterizer_top import lr_pkg::*; #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned CMD_DEPTH  = 2,
  parameter int unsigned RES_DEPTH  = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output      logic                  full,
  input  wire logic                  kind_i,
  input  wire logic [COORD_BITS-1:0] x_start_i,
  input  wire logic [COORD_BITS-1:0] y_start_i,
  input  wire logic [COORD_BITS-1:0] x_end_i,
  input  wire logic [COORD_BITS-1:0] y_end_i,
  output      logic                  empty,
  input  wire logic                  pop,
  output      logic [COORD_BITS-1:0] pixel_x_o,
  output      logic [COORD_BITS-1:0] pixel_y_o,
  output      logic                  last_o
);

  // Command word: op, four endpoints, two deltas, two directions, error term.
  localparam int unsigned CmdW = 1 + 6 * COORD_BITS + 2 + (COORD_BITS + 2);
  localparam int unsigned ResW = 2 * COORD_BITS + 1;

  // Front part outputs.
  lr_kind_e                  f_op;
  logic [COORD_BITS-1:0]     f_dx, f_dy;
  logic                      f_sx_neg, f_sy_neg;
  logic signed [COORD_BITS+1:0] f_err;

  // Command queue read side, unpacked for the back part.
  logic [CmdW-1:0]           cmd_wr, cmd_rd;
  logic                      cmd_empty;
  logic                      c_op;
  logic [COORD_BITS-1:0]     c_x0, c_y0, c_x1, c_y1, c_dx, c_dy;
  logic                      c_sx_neg, c_sy_neg;
  logic [COORD_BITS+1:0]     c_err;

  // Back part outputs and the result queue.
  lr_back_stat_t             b_stat;
  logic [COORD_BITS-1:0]     b_px, b_py;
  logic                      b_last;
  logic [ResW-1:0]           res_wr, res_rd;
  logic                      res_full;

  lr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .kind_i    (kind_i),
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .op_o      (f_op),
    .dx_o      (f_dx),
    .dy_o      (f_dy),
    .sx_neg_o  (f_sx_neg),
    .sy_neg_o  (f_sy_neg),
    .err_o     (f_err)
  );

  assign cmd_wr = {f_op, x_start_i, y_start_i, x_end_i, y_end_i, f_dx, f_dy,
                   f_sx_neg, f_sy_neg, f_err};

  lr_fifo #(
    .WIDTH(CmdW),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .data_i  (cmd_wr),
    .pop_i   (b_stat.cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_rd)
  );

  assign {c_op, c_x0, c_y0, c_x1, c_y1, c_dx, c_dy, c_sx_neg, c_sy_neg, c_err} = cmd_rd;

  lr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .op_i        (lr_kind_e'(c_op)),
    .x0_i        (c_x0),
    .y0_i        (c_y0),
    .x1_i        (c_x1),
    .y1_i        (c_y1),
    .dx_i        (c_dx),
    .dy_i        (c_dy),
    .sx_neg_i    (c_sx_neg),
    .sy_neg_i    (c_sy_neg),
    .err_i       ($signed(c_err)),
    .res_full_i  (res_full),
    .stat_o      (b_stat),
    .pixel_x_o   (b_px),
    .pixel_y_o   (b_py),
    .last_o      (b_last)
  );

  assign res_wr = {b_px, b_py, b_last};

  lr_fifo #(
    .WIDTH(ResW),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_stat.res_push),
    .full_o  (res_full),
    .data_i  (res_wr),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_rd)
  );

  assign {pixel_x_o, pixel_y_o, last_o} = res_rd;

  // A start command always produces its first pixel.
  a_start_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_stat.cmd_pop && (lr_kind_e'(c_op) == KIND_START)) |-> b_stat.res_push)
    else $error("start command consumed without a pixel");

  // The stepper never writes a pixel into a full result queue.
  a_no_res_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stat.res_push |-> !res_full)
    else $error("pixel written into a full result queue");

  // The endpoint pixel closes the line.
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_stat.res_push && b_last) |=> !b_stat.active)
    else $error("line still active after its endpoint");

  // An advance with no line in progress must not produce a pixel.
  a_idle_advance_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_stat.cmd_pop && (lr_kind_e'(c_op) == KIND_ADVANCE) && !b_stat.active)
      |-> !b_stat.res_push)
    else $error("pixel produced by an advance while idle");

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Drives start and advance requests into the line stepper through its request
// queue, predicts every pixel with an independent Bresenham model, and checks
// the pixels that leave the result queue in order, field by field.
// ----------------------------------------------------------------------------
package lr_tb_pkg;
  import lr_pkg::*;

  localparam int unsigned COORD_BITS = 10;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } pixel_t;

  // Follows the line state of the stepper and keeps the pixels still owed.
  class pixel_scoreboard;
    pixel_t                owed_pixels[$];
    bit [COORD_BITS-1:0]   cur_x, cur_y, goal_x, goal_y;
    int                    delta_x, delta_y, error_term;
    bit                    step_x_neg, step_y_neg, active;
    int                    fails;

    task report(string msg);
      $display("MISMATCH: %s", msg);
      fails++;
    endtask

    // Returns 1 when the request is due to produce a pixel.
    function bit note_request(lr_kind_e kind, bit [COORD_BITS-1:0] xs,
                              bit [COORD_BITS-1:0] ys, bit [COORD_BITS-1:0] xe,
                              bit [COORD_BITS-1:0] ye);
      int e2;
      bit done;
      if (kind == KIND_START) begin
        cur_x      = xs;
        cur_y      = ys;
        goal_x     = xe;
        goal_y     = ye;
        step_x_neg = !(xs < xe);
        step_y_neg = !(ys < ye);
        delta_x    = (xe >= xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
        delta_y    = (ye >= ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
        error_term = (delta_x > delta_y) ? delta_x / 2 : -(delta_y / 2);
      end else if (!active) begin
        return 1'b0;
      end else begin
        e2 = error_term;
        if (e2 > -delta_x) begin
          error_term -= delta_y;
          cur_x = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
        end
        if (e2 < delta_y) begin
          error_term += delta_x;
          cur_y = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
        end
      end
      done = (cur_x == goal_x) && (cur_y == goal_y);
      owed_pixels.push_back('{x: cur_x, y: cur_y, last: done});
      active = !done;
      return 1'b1;
    endfunction

    task check_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                     logic lst);
      pixel_t want;
      if (owed_pixels.size() == 0) begin
        report($sformatf("pixel (%0d,%0d) last=%0b with none owed", px, py, lst));
        return;
      end
      want = owed_pixels.pop_front();
      if (px !== want.x)
        report($sformatf("pixel_x %0d, want %0d", px, want.x));
      if (py !== want.y)
        report($sformatf("pixel_y %0d, want %0d", py, want.y));
      if (lst !== want.last)
        report($sformatf("last %0b, want %0b at (%0d,%0d)", lst, want.last,
                         want.x, want.y));
    endtask
  endclass

endpackage

module tb_top;
  import lr_pkg::*;
  import lr_tb_pkg::*;

  // Receiver behaviour, chosen afresh for each stretch of cycles.
  typedef enum int {
    DRAIN_ALL,
    DRAIN_HALF,
    DRAIN_SPARSE,
    DRAIN_RHYTHM
  } drain_mode_e;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_COORD   = (1 << COORD_BITS) - 1;

  // Every input of the block holds a known value from time zero onwards.
  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  push      = 1'b0;
  logic                  pop       = 1'b0;
  logic                  kind_i    = KIND_ADVANCE;
  logic [COORD_BITS-1:0] x_start_i = '0;
  logic [COORD_BITS-1:0] y_start_i = '0;
  logic [COORD_BITS-1:0] x_end_i   = '0;
  logic [COORD_BITS-1:0] y_end_i   = '0;
  logic                  full;
  logic                  empty;
  logic [COORD_BITS-1:0] pixel_x_o;
  logic [COORD_BITS-1:0] pixel_y_o;
  logic                  last_o;

  pixel_scoreboard board = new();
  int              cycles;
  int              pixel_requests;
  int              burst_left;

  line_rasterizer_top #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .kind_i   (kind_i),
    .x_start_i(x_start_i),
    .y_start_i(y_start_i),
    .x_end_i  (x_end_i),
    .y_end_i  (y_end_i),
    .empty    (empty),
    .pop      (pop),
    .pixel_x_o(pixel_x_o),
    .pixel_y_o(pixel_y_o),
    .last_o   (last_o)
  );

  always #5 clk_i = ~clk_i;

  // A hung handshake must not leave the run spinning for ever.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("line_rasterizer_top regression: fail");
      $finish;
    end
  end

  // Keeps an endpoint inside the coordinate range.
  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > MAX_COORD) ? MAX_COORD : v;
  endfunction

  // Offers one request and returns once it has been accepted. The sender works
  // in bursts: when a burst runs out, push drops for a random gap and a new
  // burst length is drawn. A quarter of the bursts follow on with no gap, so
  // that long unbroken streams of requests are also seen.
  task automatic offer(lr_kind_e kind, int xs, int ys, int xe, int ye);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push      <= 1'b1;
    kind_i    <= kind;
    x_start_i <= xs[COORD_BITS-1:0];
    y_start_i <= ys[COORD_BITS-1:0];
    x_end_i   <= xe[COORD_BITS-1:0];
    y_end_i   <= ye[COORD_BITS-1:0];
    do @(posedge clk_i); while (full !== 1'b0);
    if (board.note_request(kind, xs[COORD_BITS-1:0], ys[COORD_BITS-1:0],
                           xe[COORD_BITS-1:0], ye[COORD_BITS-1:0]))
      pixel_requests++;
  endtask

  // An advance request carries coordinates that the block must ignore, so
  // they are filled with random values.
  task automatic offer_advance();
    offer(KIND_ADVANCE, $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
          $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD));
  endtask

  // Pixel receiver. It takes pixels on a pattern that is drawn afresh at random
  // times, and twice it stops taking them for a long stretch while the sender
  // keeps going, so that both queues fill up and full is raised.
  initial begin : drain
    drain_mode_e mode;
    int          mode_left;
    int          hold_left;
    int          seen;
    int          beat;
    mode_left = 0;
    hold_left = 0;
    seen      = 0;
    beat      = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && empty === 1'b0) begin
        board.check_pixel(pixel_x_o, pixel_y_o, last_o);
        seen++;
        if (seen == 150 || seen == 700)
          hold_left = 80;
      end
      if (mode_left == 0) begin
        mode      = drain_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          DRAIN_ALL:    pop <= 1'b1;
          DRAIN_HALF:   pop <= 1'($urandom_range(0, 1));
          DRAIN_SPARSE: pop <= ($urandom_range(0, 3) == 0);
          default:      pop <= (beat % 3 != 2);
        endcase
      end
    end
  end

  initial begin : stimulus
    int x0, y0, x1, y1;
    int span, len, adv, extra, pick, long_done;
    long_done  = 0;
    burst_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. An advance straight after reset finds no line and must
    // give nothing; single-point lines at both corners end at once; long
    // diagonals are cut short by a fresh start; short lines in several
    // octants run to their endpoint, the first of them followed by an advance
    // that finds the block idle again.
    offer(KIND_ADVANCE, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
    offer(KIND_START, 0, 0, 0, 0);
    offer_advance();
    offer(KIND_START, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
    offer(KIND_START, 0, 0, MAX_COORD, MAX_COORD);
    offer_advance();
    offer_advance();
    offer(KIND_START, MAX_COORD, 0, 0, MAX_COORD);
    offer_advance();
    offer_advance();
    offer(KIND_START, 0, MAX_COORD, MAX_COORD, 0);
    offer(KIND_START, 10, 20, 13, 21);
    repeat (3) offer_advance();
    offer_advance();
    offer(KIND_START, 40, 40, 39, 44);
    repeat (4) offer_advance();
    offer(KIND_START, 7, 9, 7, 6);
    repeat (3) offer_advance();

    // Random part: mostly complete lines with random endpoints, some of them
    // abandoned part-way by the next start, some followed by stray advances.
    // Every long line but the first is cut short; the first is treated like a short one.
    while (pixel_requests < 1350) begin
      pick = $urandom_range(0, 99);
      x0   = $urandom_range(0, MAX_COORD);
      y0   = $urandom_range(0, MAX_COORD);
      if (pick < 80) begin
        span = $urandom_range(0, 16);
        x1   = clamp_coord(x0 + $urandom_range(0, 2 * span) - span);
        y1   = clamp_coord(y0 + $urandom_range(0, 2 * span) - span);
      end else if (pick < 90) begin
        // Endpoints at or next to the edges of the coordinate range.
        x0 = $urandom_range(0, 1) ? MAX_COORD - $urandom_range(0, 2) : $urandom_range(0, 2);
        y0 = $urandom_range(0, 1) ? MAX_COORD - $urandom_range(0, 2) : $urandom_range(0, 2);
        x1 = $urandom_range(0, 1) ? MAX_COORD - $urandom_range(0, 2) : $urandom_range(0, 2);
        y1 = $urandom_range(0, 1) ? MAX_COORD - $urandom_range(0, 2) : $urandom_range(0, 2);
      end else begin
        x1 = $urandom_range(0, MAX_COORD);
        y1 = $urandom_range(0, MAX_COORD);
      end
      len  = (x1 > x0) ? x1 - x0 : x0 - x1;
      span = (y1 > y0) ? y1 - y0 : y0 - y1;
      if (span > len)
        len = span;
      pick  = $urandom_range(0, 9);
      extra = (pick == 9) ? $urandom_range(1, 3) : 0;
      if (len > 48 && long_done > 0) begin
        adv = $urandom_range(0, 40);
      end else begin
        if (len > 48)
          long_done++;
        adv = (pick < 2) ? $urandom_range(0, len) : len;
      end
      if (adv < len)
        extra = 0;
      offer(KIND_START, x0, y0, x1, y1);
      repeat (adv + extra) offer_advance();
    end
    push <= 1'b0;

    // Wait for every owed pixel, then wait on in case a stray pixel trails
    // behind the last one.
    while (board.owed_pixels.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.owed_pixels.size() != 0)
      board.report($sformatf("%0d pixels never arrived", board.owed_pixels.size()));

    if (board.fails == 0) begin
      $display("line_rasterizer_top regression: pass");
    end else begin
      $display("line_rasterizer_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lr_pkg.sv
hw/rtl/lr_fifo.sv
hw/rtl/lr_front.sv
hw/rtl/lr_back.sv
hw/rtl/line_rasterizer_top.sv
verif/tb_top.sv
